/* design/dlts_pkg.sv */
// Shared types and constants for the delta-list task scheduler.
`default_nettype none

package dlts_pkg;

  // Field widths
  localparam int TAG_W  = 8;
  localparam int TIME_W = 32;
  localparam int SLOT_W = 5;
  localparam int MODE_W = 2;

  // Default table depth
  localparam int DEF_MAX_TASKS = 16;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISP = 2'd2;

  // Input request
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TAG_W-1:0]  task_tag;
    logic [TIME_W-1:0] start_delay;
    logic [TIME_W-1:0] repeat_period;
  } in_t;

  // Result
  typedef struct packed {
    logic              status;
    logic              fired;
    logic [TAG_W-1:0]  fired_tag;
    logic [SLOT_W-1:0] slot;
  } out_t;

  // One list entry
  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] delta;
    logic [TIME_W-1:0] period;
    logic              due;
  } entry_t;

  // List operations
  typedef enum logic [1:0] {
    RING_HOLD,
    RING_SHIFT,
    RING_HEAD
  } ring_op_t;

  // Sequencer to list control
  typedef struct packed {
    ring_op_t op;
    entry_t   push;
  } ring_ctl_t;

endpackage

`default_nettype wire

/* design/dlts_ring.sv */
// Entry list held as a ring: pops at slot 0, pushes at the top slot.
`default_nettype none

module dlts_ring #(
  parameter int MAX_TASKS = dlts_pkg::DEF_MAX_TASKS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dlts_pkg::ring_ctl_t ctl,
  output dlts_pkg::entry_t       head,
  output logic                   last_valid
);

  dlts_pkg::entry_t ring_r [MAX_TASKS];

  // Shift towards slot 0, or rewrite the head in place
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      case (ctl.op)
        dlts_pkg::RING_SHIFT: begin
          for (int i = 0; i < MAX_TASKS - 1; i++) begin
            ring_r[i] <= ring_r[i+1];
          end
          ring_r[MAX_TASKS-1] <= ctl.push;
        end
        dlts_pkg::RING_HEAD: begin
          ring_r[0] <= ctl.push;
        end
        default: begin
        end
      endcase
    end
  end

  assign head       = ring_r[0];
  // list is compact, so the top slot tells whether it is full
  assign last_valid = ring_r[MAX_TASKS-1].valid;

endmodule

`default_nettype wire

/* design/delta_list_task_scheduler.sv */
// Delta-list timer queue: top level with sequencer and shared subtractor.
// A tick, a dispatch that finds no due head or a one-shot head, and a rejected add each
// go from S_EXEC straight to S_DONE. An add, and a dispatch that reloads a periodic
// task, pass through S_WALK as well: the list is walked once right round its ring, one entry
// per cycle through a single 33-bit subtractor, popping at the head and pushing at the
// tail, with the new task dropped in at its place and later entries riding one slot behind.
// The input is ready only while the sequencer is idle; a finished result sits in an output
// register and does not hold off the next request.
`default_nettype none

module delta_list_task_scheduler #(
  parameter int MAX_TASKS = dlts_pkg::DEF_MAX_TASKS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dlts_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output dlts_pkg::out_t     out_data
);

  localparam int CNT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_TASKS - 1);
  localparam logic [dlts_pkg::SLOT_W-1:0] SLOT_NONE = dlts_pkg::SLOT_W'(MAX_TASKS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  logic [dlts_pkg::MODE_W-1:0]   mode_r, mode_nxt;
  logic [dlts_pkg::TAG_W-1:0]    tag_r, tag_nxt;
  logic [dlts_pkg::TIME_W-1:0]   delay_r, delay_nxt;
  logic [dlts_pkg::TIME_W-1:0]   period_r, period_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          searching_r, searching_nxt;
  logic                          adj_r, adj_nxt;
  dlts_pkg::entry_t              carry_r, carry_nxt;
  dlts_pkg::out_t                res_r, res_nxt;
  logic                          out_valid_r, out_valid_nxt;
  dlts_pkg::out_t                out_r, out_nxt;

  dlts_pkg::ring_ctl_t           ring_ctl;
  dlts_pkg::entry_t              head;
  logic                          last_valid;

  logic [dlts_pkg::TIME_W-1:0]   op_a, op_b;
  logic [dlts_pkg::TIME_W:0]     sub;
  logic                          borrow;
  logic [dlts_pkg::TIME_W-1:0]   diff;
  logic [dlts_pkg::TIME_W-1:0]   tick_delta;
  dlts_pkg::entry_t              new_entry;
  dlts_pkg::entry_t              tick_entry;
  dlts_pkg::entry_t              carry_out;

  dlts_ring #(
    .MAX_TASKS (MAX_TASKS)
  ) u_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ring_ctl),
    .head       (head),
    .last_valid (last_valid)
  );

  // Operand select for the shared subtractor
  always_comb begin
    op_a = delay_r;
    op_b = head.valid ? head.delta : '0;
    if (state_r == S_EXEC) begin
      op_a = head.delta;
      op_b = dlts_pkg::TIME_W'(1);
    end else if (state_r == S_WALK && !searching_r) begin
      // entry after the insert point loses the new task's delay
      op_a = carry_r.delta;
      op_b = delay_r;
    end
  end

  assign sub    = {1'b0, op_a} - {1'b0, op_b};
  assign borrow = sub[dlts_pkg::TIME_W];
  assign diff   = sub[dlts_pkg::TIME_W-1:0];

  // Candidate entries
  always_comb begin
    tick_delta = borrow ? head.delta : diff;
    tick_entry = head;
    tick_entry.delta = tick_delta;
    tick_entry.due   = (tick_delta == '0);

    new_entry.valid  = 1'b1;
    new_entry.tag    = tag_r;
    new_entry.delta  = delay_r;
    new_entry.period = period_r;
    new_entry.due    = (delay_r == '0);

    carry_out = carry_r;
    if (adj_r) begin
      carry_out.delta = diff;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    tag_nxt       = tag_r;
    delay_nxt     = delay_r;
    period_nxt    = period_r;
    cnt_nxt       = cnt_r;
    searching_nxt = searching_r;
    adj_nxt       = adj_r;
    carry_nxt     = carry_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ring_ctl.op   = dlts_pkg::RING_HOLD;
    ring_ctl.push = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_data.mode;
          tag_nxt    = in_data.task_tag;
          delay_nxt  = in_data.start_delay;
          period_nxt = in_data.repeat_period;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        res_nxt.status    = 1'b0;
        res_nxt.fired     = 1'b0;
        res_nxt.fired_tag = '0;
        res_nxt.slot      = SLOT_NONE;
        cnt_nxt           = '0;
        searching_nxt     = 1'b1;
        adj_nxt           = 1'b0;
        state_nxt         = S_DONE;
        case (mode_r)
          dlts_pkg::MODE_TICK: begin
            if (head.valid && !head.due) begin
              ring_ctl.op   = dlts_pkg::RING_HEAD;
              ring_ctl.push = tick_entry;
            end
          end
          dlts_pkg::MODE_ADD: begin
            if (last_valid) begin
              res_nxt.status = 1'b1;
            end else begin
              state_nxt = S_WALK;
            end
          end
          dlts_pkg::MODE_DISP: begin
            if (head.valid && head.due) begin
              res_nxt.fired     = 1'b1;
              res_nxt.fired_tag = head.tag;
              // drop the head; the list closes up
              ring_ctl.op       = dlts_pkg::RING_SHIFT;
              ring_ctl.push     = '0;
              if (head.period != '0) begin
                tag_nxt    = head.tag;
                delay_nxt  = head.period;
                period_nxt = head.period;
                state_nxt  = S_WALK;
              end
            end
          end
          default: begin
          end
        endcase
      end

      S_WALK: begin
        ring_ctl.op = dlts_pkg::RING_SHIFT;
        cnt_nxt     = CNT_W'(cnt_r + 1'b1);
        carry_nxt   = head;
        adj_nxt     = 1'b0;
        if (searching_r) begin
          if (!head.valid || borrow) begin
            // insert point: new task goes in, head rides one slot behind
            ring_ctl.push = new_entry;
            adj_nxt       = 1'b1;
            searching_nxt = 1'b0;
            if (mode_r == dlts_pkg::MODE_ADD) begin
              res_nxt.slot = dlts_pkg::SLOT_W'(cnt_r);
            end
          end else begin
            ring_ctl.push = head;
            delay_nxt     = diff;
          end
        end else begin
          ring_ctl.push = carry_out;
        end
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r      <= mode_nxt;
    tag_r       <= tag_nxt;
    delay_r     <= delay_nxt;
    period_r    <= period_nxt;
    cnt_r       <= cnt_nxt;
    searching_r <= searching_nxt;
    adj_r       <= adj_nxt;
    carry_r     <= carry_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted request did not enter execution");

  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && cnt_r == CNT_LAST) |=> (state_r == S_DONE))
    else $error("list walk did not end after one full turn");

  a_add_placed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && mode_r == dlts_pkg::MODE_ADD && !res_r.status) |-> !searching_r)
    else $error("add finished without placing the task");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |-> (out_data.slot == SLOT_NONE && !out_data.fired))
    else $error("full-table result carries a slot or a dispatch");

endmodule

`default_nettype wire
